// ----- design/dkc_pkg.sv -----
`timescale 1ns / 1ps
package dkc_pkg;

   localparam int WIN_DEPTH = 7;
   localparam int OUT_BITS  = 32;

   localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_COLON = 8'h3a;

   // Keywords, last character in the low byte
   localparam logic [23:0] KW_IF      = "if(";
   localparam logic [47:0] KW_WHILE   = "while(";
   localparam logic [31:0] KW_FOR     = "for(";
   localparam logic [7:0]  KW_QUEST   = "?";
   localparam logic [15:0] KW_AND     = "&&";
   localparam logic [15:0] KW_OR      = "||";
   localparam logic [31:0] KW_CASE    = "case";
   localparam logic [63:0] KW_DEFAULT = "default:";

   typedef struct packed {
      logic [7:0] char_code;
      logic       line_end;
      logic       text_end;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] complexity;
      logic [OUT_BITS-1:0] line_total;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_CHAR = 2'd0,
      OP_LINE = 2'd1,
      OP_TEXT = 2'd2
   } op_type;

   typedef struct packed {
      op_type op;
      logic   dec_hit;
      logic   case_hit;
      logic   colon;
      logic   close_line;
   } cmd_type;

endpackage

// ----- design/dkc_front.sv -----
`timescale 1ns / 1ps
module dkc_front
   import dkc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   input  logic    q_full,
   output logic    req_stall,
   output logic    push,
   output cmd_type cmd
);

   logic [WIN_DEPTH-1:0][7:0] recent_ff, recent_in;
   logic [2:0]                holdoff_ff, holdoff_in;
   logic                      line_open_ff, line_open_in;

   logic [8*(WIN_DEPTH+1)-1:0] win;
   logic                       accept;
   logic                       is_space;
   logic                       is_colon;
   logic                       dec_hit;
   logic                       case_hit;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // distance 0 (current byte) sits in the low byte
   assign win = {recent_ff, req_data.char_code};

   assign is_space = (req_data.char_code == CHAR_SPACE) ||
                     ((req_data.char_code >= CHAR_TAB) && (req_data.char_code <= CHAR_CR));
   assign is_colon = (req_data.char_code == CHAR_COLON);

   // a keyword of length L may not start inside the previous match
   always_comb begin
      dec_hit = ((win[23:0] == KW_IF)      && (holdoff_ff <= 3'd5)) ||
                ((win[47:0] == KW_WHILE)   && (holdoff_ff <= 3'd2)) ||
                ((win[31:0] == KW_FOR)     && (holdoff_ff <= 3'd4)) ||
                (win[7:0] == KW_QUEST)                              ||
                ((win[15:0] == KW_AND)     && (holdoff_ff <= 3'd6)) ||
                ((win[15:0] == KW_OR)      && (holdoff_ff <= 3'd6)) ||
                ((win[63:0] == KW_DEFAULT) && (holdoff_ff == 3'd0));
      case_hit = (win[31:0] == KW_CASE) && (holdoff_ff <= 3'd4);
   end

   always_comb begin
      recent_in       = recent_ff;
      holdoff_in      = holdoff_ff;
      line_open_in    = line_open_ff;
      push            = 1'b0;
      cmd.op          = OP_CHAR;
      cmd.dec_hit     = dec_hit;
      cmd.case_hit    = case_hit;
      cmd.colon       = is_colon;
      cmd.close_line  = req_data.line_end || line_open_ff;
      if (accept) begin
         if (req_data.text_end || req_data.line_end) begin
            push         = 1'b1;
            cmd.op       = req_data.text_end ? OP_TEXT : OP_LINE;
            recent_in    = '0;
            holdoff_in   = '0;
            line_open_in = 1'b0;
         end else begin
            line_open_in = 1'b1;
            if (!is_space) begin
               recent_in = {recent_ff[WIN_DEPTH-2:0], req_data.char_code};
               if (dec_hit || case_hit) begin
                  holdoff_in = 3'd7;
               end else if (holdoff_ff != 3'd0) begin
                  holdoff_in = holdoff_ff - 3'd1;
               end
               // only transactions that touch the counters go to the back end
               push = dec_hit || case_hit || is_colon;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff    <= '0;
         holdoff_ff   <= '0;
         line_open_ff <= 1'b0;
      end else begin
         recent_ff    <= recent_in;
         holdoff_ff   <= holdoff_in;
         line_open_ff <= line_open_in;
      end
   end

endmodule

// ----- design/dkc_fifo.sv -----
`timescale 1ns / 1ps
module dkc_fifo
   import dkc_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type wr_data,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type rd_data
);

   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   cmd_type                 slot_ff [DEPTH];
   logic [ADDR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ADDR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_data   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ADDR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/dkc_back.sv -----
`timescale 1ns / 1ps
module dkc_back
   import dkc_pkg::*;
#(
   parameter int COUNT_BITS   = 32,
   parameter int PENDING_BITS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int SUM_BITS = ((COUNT_BITS > PENDING_BITS) ? COUNT_BITS : PENDING_BITS) + 1;
   localparam int WIDE     = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
   localparam logic [COUNT_BITS-1:0]   COUNT_MAX   = '1;
   localparam logic [PENDING_BITS-1:0] PENDING_MAX = '1;

   logic [COUNT_BITS-1:0]   dec_ff, dec_in;
   logic [COUNT_BITS-1:0]   line_ff, line_in;
   logic [PENDING_BITS-1:0] pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [SUM_BITS-1:0]     dec_sum;
   logic [COUNT_BITS-1:0]   dec_inc;
   logic [COUNT_BITS-1:0]   line_inc;
   logic [COUNT_BITS-1:0]   line_final;
   logic [WIDE-1:0]         cx_wide;
   logic [WIDE-1:0]         ln_wide;
   logic                    out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = cmd_valid && ((cmd.op != OP_TEXT) || out_free);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // hit and pending cases fold into one add; carry past the maximum saturates
   assign dec_sum = SUM_BITS'(dec_ff)
                  + (cmd.colon ? SUM_BITS'(pend_ff) : '0)
                  + SUM_BITS'(cmd.dec_hit);

   assign dec_inc    = (dec_ff == COUNT_MAX) ? dec_ff : dec_ff + 1'b1;
   assign line_inc   = (line_ff == COUNT_MAX) ? line_ff : line_ff + 1'b1;
   assign line_final = cmd.close_line ? line_inc : line_ff;
   assign cx_wide    = WIDE'(dec_inc);
   assign ln_wide    = WIDE'(line_final);

   always_comb begin
      dec_in       = dec_ff;
      line_in      = line_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         case (cmd.op)
            OP_CHAR: begin
               dec_in = (dec_sum > SUM_BITS'(COUNT_MAX)) ? COUNT_MAX
                                                         : COUNT_BITS'(dec_sum);
               if (cmd.colon) begin
                  pend_in = '0;
               end else if (cmd.case_hit && (pend_ff != PENDING_MAX)) begin
                  pend_in = pend_ff + 1'b1;
               end
            end
            OP_LINE: begin
               line_in = line_inc;
               pend_in = '0;
            end
            OP_TEXT: begin
               rsp_in.complexity = (cx_wide > WIDE'(OUT_MAX)) ? OUT_MAX
                                                              : OUT_BITS'(cx_wide);
               rsp_in.line_total = (ln_wide > WIDE'(OUT_MAX)) ? OUT_MAX
                                                              : OUT_BITS'(ln_wide);
               rsp_valid_in = 1'b1;
               dec_in       = '0;
               line_in      = '0;
               pend_in      = '0;
            end
            default: begin
               pend_in = pend_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff       <= '0;
         line_ff      <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dec_ff       <= dec_in;
         line_ff      <= line_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/decision_keyword_counter.sv -----
`timescale 1ns / 1ps
// Channel   Ports                           Payload
// request   req_valid, req_stall, req_data  char_code, line_end, text_end
// response  rsp_valid, rsp_stall, rsp_data  complexity, line_total
//
// One character transaction per cycle while req_stall is low; the keyword window
// compare and the command queue push happen in the cycle of acceptance.
// A text end accepted into an empty queue is registered in the queue, then in rsp_valid_ff.
// Synchronous active-high reset clears window, counters and queue.
// req_stall rises only when the command queue is full, which happens only
// while rsp_stall holds a finished result and a further text end waits behind it.
module decision_keyword_counter
   import dkc_pkg::*;
#(
   parameter int COUNT_BITS   = 32,
   parameter int PENDING_BITS = 8,
   parameter int QUEUE_DEPTH  = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    q_full;
   logic    q_push;
   logic    q_pop;
   logic    q_not_empty;
   cmd_type q_wr_data;
   cmd_type q_rd_data;

   dkc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_full    (q_full),
      .req_stall (req_stall),
      .push      (q_push),
      .cmd       (q_wr_data)
   );

   dkc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wr_data   (q_wr_data),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .rd_data   (q_rd_data)
   );

   dkc_back #(
      .COUNT_BITS   (COUNT_BITS),
      .PENDING_BITS (PENDING_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_not_empty),
      .cmd       (q_rd_data),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
